>>> sv/wpm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wpm_pkg: wildcard pattern matcher shared definitions
// Sizes, operation codes, wildcard bytes and the cell control/status structs.
// ----------------------------------------------------------------------------
package wpm_pkg;

   localparam int MAX_PATTERN = 32;
   localparam int LEN_W       = $clog2(MAX_PATTERN + 1);

   localparam logic [7:0] STAR_BYTE  = 8'h2A;
   localparam logic [7:0] QMARK_BYTE = 8'h3F;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_BEGIN  = 2'd2,
      OP_TEXT   = 2'd3
   } op_type;

   // per-cell controls from the top level
   typedef struct packed {
      logic write;       // load pattern byte into this cell
      logic active;      // cell lies inside the current pattern
      logic step;        // text byte transaction
      logic begin_text;  // begin text transaction: row := empty-text row
   } cell_ctl_type;

   // per-cell status toward neighbors and the prefix unit
   typedef struct packed {
      logic m;     // match bit for this prefix
      logic e;     // empty-text match bit for this prefix
      logic gen;   // chain generate
      logic prop;  // chain propagate (star cell)
   } cell_stat_type;

endpackage
`default_nettype wire

>>> sv/wpm_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wpm_cell: one pattern position
// Holds a pattern byte and its match / empty-text bits, takes the left
// neighbor's bits and the chain result for the row update.
// ----------------------------------------------------------------------------
module wpm_cell
   import wpm_pkg::*;
(
   input  wire logic          clock,
   input  wire cell_ctl_type  ctl,
   input  wire logic [7:0]    ch,
   input  wire logic          left_m,
   input  wire logic          left_e,
   input  wire logic          chain_in,
   output cell_stat_type      stat
);

   logic [7:0] byte_ff, byte_in;
   logic       m_ff, m_in;
   logic       e_ff, e_in;
   logic       star;
   logic       hit;

   assign star = (byte_ff == STAR_BYTE);
   assign hit  = (byte_ff == QMARK_BYTE) || (byte_ff == ch);

   // inactive cells stay out of the chain
   assign stat.m    = m_ff;
   assign stat.e    = e_ff;
   assign stat.prop = ctl.active & star;
   assign stat.gen  = ctl.active & (star ? m_ff : (hit & left_m));

   always_comb begin
      byte_in = byte_ff;
      m_in    = m_ff;
      e_in    = e_ff;
      if (ctl.write) begin
         byte_in = ch;
         e_in    = (ch == STAR_BYTE) & left_e;
         m_in    = 1'b0;
      end else if (ctl.step) begin
         m_in = chain_in;
      end else if (ctl.begin_text) begin
         m_in = e_ff;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      m_ff    <= m_in;
      e_ff    <= e_in;
   end

endmodule
`default_nettype wire

>>> sv/wpm_prefix.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wpm_prefix: star-chain resolver
// Resolves next[j] = gen[j] | prop[j] & next[j-1] across all cells with one
// carry-chain add; the chain input below the first cell is zero.
// ----------------------------------------------------------------------------
module wpm_prefix
   import wpm_pkg::*;
(
   input  wire logic [MAX_PATTERN-1:0] gen,
   input  wire logic [MAX_PATTERN-1:0] prop,
   output logic      [MAX_PATTERN-1:0] chain
);

   logic [MAX_PATTERN-1:0] a_vec;
   logic [MAX_PATTERN:0]   sum;
   logic [MAX_PATTERN:0]   carry_in;

   // generate -> 1+1, propagate -> 1+0, kill -> 0+0
   assign a_vec    = gen | prop;
   assign sum      = {1'b0, a_vec} + {1'b0, gen};
   assign carry_in = sum ^ {1'b0, a_vec} ^ {1'b0, gen};
   // carry out of bit i is carry into bit i+1
   assign chain    = carry_in[MAX_PATTERN:1];

endmodule
`default_nettype wire

>>> sv/wildcard_pattern_matcher.sv
`default_nettype none
// Response: a result is registered and appears on rsp_tvalid in the cycle after its transaction is taken.
// Throughput: one transaction per cycle while the response is not held; the row update
//   for a text byte is a single pass through the star chain (one 32-bit carry add over the cells).
// Reset: synchronous; clears pattern length, overflow flag and the response valid
//   flag, sets row bit zero, and holds req_tready low. Pattern cells are
//   loaded by append transactions only.
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher: streaming wildcard ('*', '?') pattern matcher
// Pattern bytes are loaded into a row of cells; text bytes then update one
// bit of match state per cell, and a result reports whole-pattern match.
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher
   import wpm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   // request channel
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] ch
   input  wire logic [1:0] req_tuser,   // [1:0] op
   // response channel
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);

   // --- control state -------------------------------------------------------
   logic [LEN_W-1:0] len_ff, len_in;      // pattern length
   logic             ovf_ff, ovf_in;      // bytes dropped since last clear
   logic             m0_ff, m0_in;        // match bit for the empty prefix
   logic             rsp_valid_ff, rsp_valid_in;
   logic             matched_ff, matched_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   logic             accept;
   op_type           op;
   logic             full;

   cell_ctl_type     cell_ctl  [MAX_PATTERN];
   cell_stat_type    cell_stat [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] gen_vec;
   logic [MAX_PATTERN-1:0] prop_vec;
   logic [MAX_PATTERN-1:0] chain_vec;
   logic [MAX_PATTERN-1:0] e_vec;
   logic [MAX_PATTERN:0]   empty_row;     // empty-text row, bit zero always set
   logic [MAX_PATTERN:0]   next_row;      // match row after the current text byte

   // output register frees the input side whenever it can be emptied;
   // nothing is taken while reset is high
   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign op         = op_type'(req_tuser);
   assign full       = (len_ff == LEN_W'(MAX_PATTERN));

   // --- cell row ------------------------------------------------------------
   // Cell i holds pattern prefix length i+1. Match and empty bits move right
   // from neighbor to neighbor; star cells chain through the prefix unit.
   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
      logic left_m;
      logic left_e;

      if (i == 0) begin : g_first
         assign left_m = m0_ff;
         assign left_e = 1'b1;
      end else begin : g_rest
         assign left_m = cell_stat[i-1].m;
         assign left_e = cell_stat[i-1].e;
      end

      assign cell_ctl[i].write      = accept && (op == OP_APPEND) &&
                                      (len_ff == LEN_W'(i));
      assign cell_ctl[i].active     = (len_ff >= LEN_W'(i + 1));
      assign cell_ctl[i].step       = accept && (op == OP_TEXT);
      assign cell_ctl[i].begin_text = accept && (op == OP_BEGIN);

      wpm_cell u_cell (
         .clock    (clock),
         .ctl      (cell_ctl[i]),
         .ch       (req_tdata),
         .left_m   (left_m),
         .left_e   (left_e),
         .chain_in (chain_vec[i]),
         .stat     (cell_stat[i])
      );

      assign gen_vec[i]  = cell_stat[i].gen;
      assign prop_vec[i] = cell_stat[i].prop;
      assign e_vec[i]    = cell_stat[i].e;
   end

   wpm_prefix u_prefix (
      .gen   (gen_vec),
      .prop  (prop_vec),
      .chain (chain_vec)
   );

   // a text byte never matches the empty prefix
   assign empty_row = {e_vec, 1'b1};
   assign next_row  = {chain_vec, 1'b0};

   // --- next state ----------------------------------------------------------
   always_comb begin
      len_in       = len_ff;
      ovf_in       = ovf_ff;
      m0_in        = m0_ff;
      matched_in   = matched_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (accept) begin
         unique case (op)
            OP_CLEAR: begin
               len_in = '0;
               ovf_in = 1'b0;
               m0_in  = 1'b1;
            end
            OP_APPEND: begin
               if (full) begin
                  ovf_in = 1'b1;          // byte dropped
               end else begin
                  len_in = len_ff + LEN_W'(1);
               end
            end
            OP_BEGIN: begin
               m0_in        = 1'b1;
               matched_in   = empty_row[len_ff];
               rsp_ovf_in   = ovf_ff;
               rsp_valid_in = 1'b1;
            end
            OP_TEXT: begin
               m0_in        = 1'b0;
               matched_in   = next_row[len_ff];
               rsp_ovf_in   = ovf_ff;
               rsp_valid_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         m0_ff        <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         m0_ff        <= m0_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      matched_ff <= matched_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_ovf_ff, matched_ff};

   // --- assertions ----------------------------------------------------------
   a_len_bound : assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(MAX_PATTERN))
      else $error("pattern length beyond capacity");

   a_ovf_cause : assert property (@(posedge clock) disable iff (reset)
      $rose(ovf_ff) |-> $past(accept && (op == OP_APPEND) && full))
      else $error("overflow flag set without a dropped append");

   a_clear : assert property (@(posedge clock) disable iff (reset)
      accept && (op == OP_CLEAR) |=> (len_ff == '0) && !ovf_ff && m0_ff)
      else $error("clear did not reset pattern state");

   a_empty_begin : assert property (@(posedge clock) disable iff (reset)
      accept && (op == OP_BEGIN) && (len_ff == '0) |=> rsp_tvalid && rsp_tdata[0])
      else $error("empty pattern must match empty text");

endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for wildcard_pattern_matcher
// Loads wildcard patterns, streams text against them, and compares every
// response transaction with a bit-level prediction of the match row.
// ----------------------------------------------------------------------------
import wpm_pkg::*;

typedef struct packed {
   logic matched;
   logic overflow;
} match_result_type;

// Tracks the pattern, both match rows and the overflow flag, and queues the
// result each begin-text or text-byte transaction should produce.
class match_scoreboard;
   logic [7:0]           pat_mem [MAX_PATTERN];
   int                   pat_len;
   logic [MAX_PATTERN:0] blank_row;   // empty text vs. each pattern prefix
   logic [MAX_PATTERN:0] live_row;    // text so far vs. each pattern prefix
   logic                 dropped;
   match_result_type     expected_q [$];
   int                   failures;

   function new();
      pat_len   = 0;
      dropped   = 1'b0;
      blank_row = {{MAX_PATTERN{1'b0}}, 1'b1};
      live_row  = {{MAX_PATTERN{1'b0}}, 1'b1};
      failures  = 0;
   endfunction

   function void flag(string msg);
      if (failures < 10)
         $display("%s", msg);
      failures++;
   endfunction

   function void note_request(op_type op, logic [7:0] ch);
      logic [MAX_PATTERN:0] next_row;
      match_result_type     res;
      int                   j;
      next_row = '0;
      case (op)
         OP_CLEAR: begin
            pat_len   = 0;
            dropped   = 1'b0;
            blank_row = {{MAX_PATTERN{1'b0}}, 1'b1};
            live_row  = {{MAX_PATTERN{1'b0}}, 1'b1};
         end
         OP_APPEND: begin
            if (pat_len >= MAX_PATTERN) begin
               dropped = 1'b1;
            end else begin
               pat_mem[pat_len]     = ch;
               blank_row[pat_len+1] = (ch == STAR_BYTE) ? blank_row[pat_len] : 1'b0;
               // new column starts cold when appended mid-text
               live_row[pat_len+1]  = 1'b0;
               pat_len++;
            end
         end
         OP_BEGIN: begin
            live_row = blank_row;
         end
         OP_TEXT: begin
            for (j = 1; j <= pat_len; j++) begin
               if (pat_mem[j-1] == STAR_BYTE)
                  next_row[j] = next_row[j-1] | live_row[j];
               else if (pat_mem[j-1] == QMARK_BYTE || pat_mem[j-1] == ch)
                  next_row[j] = live_row[j-1];
               else
                  next_row[j] = 1'b0;
            end
            live_row = next_row;
         end
      endcase
      if (op == OP_BEGIN || op == OP_TEXT) begin
         res.matched  = live_row[pat_len];
         res.overflow = dropped;
         expected_q.push_back(res);
      end
   endfunction

   function void check_response(logic [7:0] data);
      match_result_type want;
      if (expected_q.size() == 0) begin
         flag($sformatf("unexpected response transaction: tdata=%h", data));
         return;
      end
      want = expected_q.pop_front();
      if (data[0] !== want.matched || data[1] !== want.overflow || data[7:2] !== 6'd0)
         flag($sformatf("response: matched %b/%b overflow %b/%b pad %h/00 (got/want)",
                        data[0], want.matched, data[1], want.overflow, data[7:2]));
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   function void flush_check();
      if (expected_q.size() != 0)
         flag($sformatf("%0d response transactions never arrived", expected_q.size()));
   endfunction
endclass

module tb;

   localparam int ITEM_TARGET = 950;
   localparam int IDLE_LIMIT  = 2000;   // cycles with no transaction on either side

   logic       clock;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;     // [7:0] ch
   logic [1:0] req_tuser  = 2'd0;      // [1:0] op
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;              // [0] matched, [1] pattern_overflow, [7:2] zero

   match_scoreboard sb;

   int items_sent  = 0;
   int burst_left  = 0;
   bit valid_high  = 1'b0;
   int idle_cycles = 0;
   int rx_cycle    = 0;
   int rx_mode     = 0;
   int stall_left  = 0;

   wildcard_pattern_matcher uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Drive one request and hold it until taken. Bursts end in a random gap;
   // valid stays high across back-to-back items so it is never toggled
   // within a single step.
   task automatic send_item(input op_type op, input logic [7:0] ch);
      int gap;
      if (burst_left == 0)
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 16);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= ch;
      valid_high  = 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      sb.note_request(op, ch);
      items_sent++;
      burst_left--;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 5);
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom_range(0, 255));
         req_tuser  <= 2'($urandom_range(0, 3));
         valid_high  = 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [7:0] pick_pattern_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) return STAR_BYTE;
      if (r < 50) return QMARK_BYTE;
      if (r < 85) return 8'h61 + 8'($urandom_range(0, 2));
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] pick_text_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 8'h61 + 8'($urandom_range(0, 2));
      if (r < 80) return ($urandom_range(0, 1) != 0) ? STAR_BYTE : QMARK_BYTE;
      return 8'($urandom_range(0, 255));
   endfunction

   // Response side: check on each handshake, then pick tready from a
   // randomly chosen stall pattern mode.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata);
      rx_cycle++;
      if (rx_cycle % 50 == 0)
         rx_mode = $urandom_range(0, 3);
      case (rx_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) == 0);
         2: rsp_tready <= (rx_cycle % 3 != 0);
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               rsp_tready <= 1'b0;
            end else begin
               stall_left  = $urandom_range(0, 12);
               rsp_tready <= 1'b1;
            end
         end
      endcase
   end

   // Watchdog: the run ends as a mismatch once idle_cycles with no handshake on either channel reach IDLE_LIMIT.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("wildcard_pattern_matcher: mismatch");
         $finish;
      end
   end

   initial begin
      logic [7:0] pat_q [$];
      logic [7:0] text_q [$];
      logic [7:0] c;
      int         plen;
      int         sel;
      int         k;
      int         n;

      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed ----
      send_item(OP_BEGIN,  8'hFF);        // empty pattern, empty text: match
      send_item(OP_TEXT,   8'h00);        // empty pattern, any text: no match
      send_item(OP_CLEAR,  8'hFF);
      send_item(OP_TEXT,   8'h61);        // text with no begin after clear
      send_item(OP_APPEND, STAR_BYTE);
      send_item(OP_BEGIN,  8'h00);        // lone star matches empty text
      send_item(OP_TEXT,   8'hFF);
      send_item(OP_TEXT,   8'h00);
      send_item(OP_CLEAR,  8'h00);
      send_item(OP_APPEND, 8'h61);        // a ? * b
      send_item(OP_APPEND, QMARK_BYTE);
      send_item(OP_APPEND, STAR_BYTE);
      send_item(OP_APPEND, 8'h62);
      send_item(OP_BEGIN,  8'h55);
      send_item(OP_TEXT,   8'h61);
      send_item(OP_TEXT,   8'h80);        // '?' takes a high-bit byte
      send_item(OP_TEXT,   8'h7A);
      send_item(OP_TEXT,   8'h62);
      send_item(OP_APPEND, 8'h63);        // append in the middle of a text
      send_item(OP_TEXT,   8'h63);
      send_item(OP_BEGIN,  8'hAA);
      send_item(OP_TEXT,   STAR_BYTE);    // literal star byte in the text
      send_item(OP_TEXT,   QMARK_BYTE);

      // ---- random: mostly clear / pattern / begin / text sequences ----
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 99) < 85) begin
            // occasionally keep the old pattern and extend it
            if ($urandom_range(0, 9) != 0) begin
               send_item(OP_CLEAR, 8'($urandom_range(0, 255)));
               pat_q.delete();
            end
            sel = $urandom_range(0, 99);
            if (sel < 70)
               plen = $urandom_range(0, 6);
            else if (sel < 90)
               plen = $urandom_range(7, 20);
            else
               plen = $urandom_range(28, 36);   // up to and past capacity
            for (k = 0; k < plen; k++) begin
               c = pick_pattern_byte();
               pat_q.push_back(c);
               send_item(OP_APPEND, c);
            end
            if ($urandom_range(0, 9) != 0)
               send_item(OP_BEGIN, 8'($urandom_range(0, 255)));

            // text: usually built to fit the pattern, then maybe corrupted
            text_q.delete();
            if ($urandom_range(0, 2) != 0) begin
               foreach (pat_q[k]) begin
                  if (pat_q[k] == STAR_BYTE) begin
                     n = $urandom_range(0, 3);
                     repeat (n) text_q.push_back(pick_text_byte());
                  end else if (pat_q[k] == QMARK_BYTE) begin
                     text_q.push_back(8'($urandom_range(0, 255)));
                  end else begin
                     text_q.push_back(pat_q[k]);
                  end
               end
               if (text_q.size() > 0 && $urandom_range(0, 3) == 0)
                  text_q[$urandom_range(0, text_q.size() - 1)] = pick_text_byte();
            end else begin
               n = $urandom_range(0, 10);
               repeat (n) text_q.push_back(pick_text_byte());
            end
            foreach (text_q[k]) begin
               if ($urandom_range(0, 19) == 0)
                  send_item(OP_APPEND, pick_pattern_byte());
               send_item(OP_TEXT, text_q[k]);
            end
         end else begin
            n = $urandom_range(1, 5);
            repeat (n) send_item(op_type'(2'($urandom_range(0, 3))),
                                 8'($urandom_range(0, 255)));
         end
      end
      if (valid_high) begin
         req_tvalid <= 1'b0;
         valid_high  = 1'b0;
      end

      // drain, then wait out any stray response before the final check
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      sb.flush_check();
      if (sb.failures == 0)
         $display("wildcard_pattern_matcher: match");
      else
         $display("wildcard_pattern_matcher: mismatch");
      $finish;
   end

endmodule
